>>> rtl/core/mscd_pkg.sv
// ----------------------------------------------------------------------------
// mscd_pkg
// shared codes, defaults and the event record for the countdown timer core
// ----------------------------------------------------------------------------
`default_nettype none

package mscd_pkg;

  localparam int SLOTS_DEF       = 16;
  localparam int PERIOD_BITS_DEF = 16;
  localparam int MAX_RESULTS     = 16;

  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 6;
  localparam int PORT_PER = 16;
  localparam int STATUS_W = 3;
  localparam int MODE_W   = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_CANCEL = 3'd2,
    CMD_REAP   = 3'd3,
    CMD_PAUSE  = 3'd4,
    CMD_RESUME = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_BUSY    = 3'd2,
    ST_NOSPACE = 3'd3,
    ST_PENDING = 3'd4,
    ST_WRONG   = 3'd5
  } status_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_EMPTY  = 3'd0,
    MODE_RUN    = 3'd1,
    MODE_CANCEL = 3'd2,
    MODE_OVER   = 3'd3,
    MODE_PAUSE  = 3'd4
  } mode_t;

  // one event from the engine to the result stage, at most one of fire, reply and flush set
  typedef struct packed {
    logic              fire;
    logic              reply;
    logic              flush;
    logic [SLOT_W-1:0] slot;
    status_t           status;
    logic              freed;
  } evt_t;

endpackage

`default_nettype wire

>>> rtl/core/mscd_slot_ram.sv
// ----------------------------------------------------------------------------
// mscd_slot_ram
// slot table storage, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mscd_slot_ram #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 36,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mscd_result_stage.sv
// ----------------------------------------------------------------------------
// mscd_result_stage
// result register; holds back one fire beat so the final one gets last
// ----------------------------------------------------------------------------
`default_nettype none

module mscd_result_stage
  import mscd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire evt_t              evt,
  output logic                   out_strobe,
  output logic                   out_kind,
  output logic [SLOT_W-1:0]      out_slot_out,
  output logic [STATUS_W-1:0]    out_status,
  output logic                   out_freed,
  output logic                   out_last
);

  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  logic              pend_v_r;
  logic [SLOT_W-1:0] pend_slot_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              fire_take;

  assign fire_take = evt.fire && (cnt_r < CNT_W'(MAX_RESULTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
      pend_v_r   <= 1'b0;
      cnt_r      <= '0;
    end else begin
      out_strobe <= 1'b0;
      if (evt.reply) begin
        out_strobe   <= 1'b1;
        out_kind     <= 1'b0;
        out_slot_out <= evt.slot;
        out_status   <= evt.status;
        out_freed    <= evt.freed;
        out_last     <= 1'b1;
      end
      if (fire_take) begin
        // a newer fire means the held one is not the final beat
        if (pend_v_r) begin
          out_strobe   <= 1'b1;
          out_kind     <= 1'b1;
          out_slot_out <= pend_slot_r;
          out_status   <= ST_OK;
          out_freed    <= 1'b0;
          out_last     <= 1'b0;
        end
        pend_v_r    <= 1'b1;
        pend_slot_r <= evt.slot;
        cnt_r       <= cnt_r + 1'b1;
      end
      if (evt.flush) begin
        if (pend_v_r) begin
          out_strobe   <= 1'b1;
          out_kind     <= 1'b1;
          out_slot_out <= pend_slot_r;
          out_status   <= ST_OK;
          out_freed    <= 1'b0;
          out_last     <= 1'b1;
        end
        pend_v_r <= 1'b0;
        cnt_r    <= '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mscd_engine.sv
// ----------------------------------------------------------------------------
// mscd_engine
// command sequencer: slot walk for tick and add, read-modify-write of entries
// ----------------------------------------------------------------------------
`default_nettype none

module mscd_engine
  import mscd_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF,
  localparam int AW         = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int DW         = MODE_W + 1 + 2 * PERIOD_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    in_command,
  input  wire logic [SLOT_W-1:0]   in_slot,
  input  wire logic [PORT_PER-1:0] in_period,
  input  wire logic                in_repeat_req,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  input  wire logic [DW-1:0]       rd_data,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic [DW-1:0]            wr_data,
  output evt_t                     evt
);

  localparam int PB = PERIOD_BITS;
  localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_ADD,
    S_CMD
  } state_t;

  state_t            state_r;
  logic [SLOTS-1:0]  occ_r;
  logic [AW-1:0]     idx_r;
  logic              rd_go_r;
  logic              p_v_r;
  logic [AW-1:0]     p_idx_r;
  logic [PB-1:0]     per_r;
  logic              rep_r;
  cmd_t              cmd_r;
  logic [AW-1:0]     slot_r;
  logic [SLOT_W-1:0] slot6_r;
  evt_t              evt_r;

  logic          accept;
  logic          slot_ok;
  logic          slot_cmd;
  logic [PB-1:0] in_per;
  mode_t         e_mode;
  logic          e_flag;
  logic [PB-1:0] e_ticks;
  logic [PB-1:0] e_per;
  logic [PB-1:0] t1;
  logic          fire;
  status_t       c_status;
  logic          c_freed;
  logic          c_clr;
  mode_t         n_mode;
  logic          n_flag;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign in_per   = PB'(in_period);
  assign slot_ok  = (7'(in_slot) < 7'(SLOTS)) && occ_r[in_slot[AW-1:0]];
  assign slot_cmd = (in_command == CMD_CANCEL) || (in_command == CMD_REAP)
                 || (in_command == CMD_PAUSE)  || (in_command == CMD_RESUME);
  assign evt      = evt_r;

  assign e_mode  = mode_t'(rd_data[DW-1 -: MODE_W]);
  assign e_flag  = rd_data[2*PB];
  assign e_ticks = rd_data[2*PB-1:PB];
  assign e_per   = rd_data[PB-1:0];
  assign t1      = e_ticks - PB'(1);

  always_comb begin
    rd_en   = (state_r == S_TICK) ? rd_go_r : (accept && slot_cmd && slot_ok);
    rd_addr = (state_r == S_TICK) ? idx_r : in_slot[AW-1:0];
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = idx_r;
    wr_data  = {MODE_RUN, rep_r, per_r, per_r};
    fire     = 1'b0;
    c_status = ST_OK;
    c_freed  = 1'b0;
    c_clr    = 1'b0;
    n_mode   = e_mode;
    n_flag   = e_flag;
    unique case (state_r)
      S_TICK: begin
        wr_addr = p_idx_r;
        if (p_v_r && occ_r[p_idx_r] && (e_mode == MODE_RUN)) begin
          wr_en = 1'b1;
          if (t1 == '0) begin
            fire = 1'b1;
            if (e_flag) begin
              wr_data = {e_mode, e_flag, e_per, e_per};
            end else begin
              wr_data = {MODE_OVER, e_flag, t1, e_per};
            end
          end else begin
            wr_data = {e_mode, e_flag, t1, e_per};
          end
        end
      end
      S_ADD: begin
        wr_en = !occ_r[idx_r];
      end
      S_CMD: begin
        wr_addr = slot_r;
        wr_en   = 1'b1;
        unique case (cmd_r)
          CMD_CANCEL: begin
            if (e_mode == MODE_OVER) begin
              c_status = ST_BUSY;
            end else begin
              n_mode = MODE_CANCEL;
              n_flag = 1'b0;
            end
          end
          CMD_REAP: begin
            if (e_flag) begin
              c_status = ST_BUSY;
            end else if (e_mode == MODE_RUN) begin
              c_status = ST_PENDING;
            end else if ((e_mode == MODE_CANCEL) || (e_mode == MODE_OVER)) begin
              c_clr   = 1'b1;
              c_freed = 1'b1;
            end
          end
          CMD_PAUSE: begin
            if (e_mode != MODE_RUN) c_status = ST_WRONG;
            else n_mode = MODE_PAUSE;
          end
          CMD_RESUME: begin
            if (e_mode != MODE_PAUSE) c_status = ST_WRONG;
            else n_mode = MODE_RUN;
          end
          default: begin
            wr_en = 1'b0;
          end
        endcase
        wr_data = {n_mode, n_flag, e_ticks, e_per};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
      rd_go_r <= 1'b0;
      p_v_r   <= 1'b0;
      evt_r   <= '0;
    end else begin
      evt_r <= '0;
      p_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (in_command)
              CMD_TICK: begin
                state_r <= S_TICK;
                idx_r   <= '0;
                rd_go_r <= 1'b1;
              end
              CMD_ADD: begin
                if (in_per == '0) begin
                  evt_r.reply  <= 1'b1;
                  evt_r.status <= ST_INVALID;
                end else begin
                  state_r <= S_ADD;
                  idx_r   <= '0;
                  per_r   <= in_per;
                  rep_r   <= in_repeat_req;
                end
              end
              CMD_CANCEL, CMD_REAP, CMD_PAUSE, CMD_RESUME: begin
                if (!slot_ok) begin
                  evt_r.reply  <= 1'b1;
                  evt_r.slot   <= in_slot;
                  evt_r.status <= ST_INVALID;
                end else begin
                  state_r <= S_CMD;
                  cmd_r   <= cmd_t'(in_command);
                  slot_r  <= in_slot[AW-1:0];
                  slot6_r <= in_slot;
                end
              end
              default: begin
                evt_r.reply  <= 1'b1;
                evt_r.status <= ST_INVALID;
              end
            endcase
          end
        end
        S_TICK: begin
          p_v_r   <= rd_go_r;
          p_idx_r <= idx_r;
          if (rd_go_r) begin
            if (idx_r == LAST_IDX) rd_go_r <= 1'b0;
            else idx_r <= idx_r + 1'b1;
          end
          if (fire) begin
            evt_r.fire <= 1'b1;
            evt_r.slot <= SLOT_W'(p_idx_r);
          end
          if (!rd_go_r && !p_v_r) begin
            evt_r.flush <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_ADD: begin
          if (!occ_r[idx_r]) begin
            occ_r[idx_r] <= 1'b1;
            evt_r.reply  <= 1'b1;
            evt_r.slot   <= SLOT_W'(idx_r);
            evt_r.status <= ST_OK;
            state_r      <= S_IDLE;
          end else if (idx_r == LAST_IDX) begin
            evt_r.reply  <= 1'b1;
            evt_r.status <= ST_NOSPACE;
            state_r      <= S_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_CMD: begin
          if (c_clr) occ_r[slot_r] <= 1'b0;
          evt_r.reply  <= 1'b1;
          evt_r.slot   <= slot6_r;
          evt_r.status <= c_status;
          evt_r.freed  <= c_freed;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // read and write of one entry never land in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("slot table read and write hit the same entry");

  a_evt_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({evt_r.fire, evt_r.reply, evt_r.flush}))
    else $error("more than one event in a cycle");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (!rd_go_r && !p_v_r))
    else $error("slot walk still active while idle");

  a_tick_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK && !rd_go_r && !p_v_r) |=> (evt_r.flush && !busy))
    else $error("tick walk ended without flush");

endmodule

`default_nettype wire

>>> rtl/core/multi_slot_countdown_timer_core.sv
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer_core
// table of countdown timer slots driven by tick, add, cancel, reap, pause
// and resume commands
// ----------------------------------------------------------------------------
// usage
//   - a command beat is taken on a rising edge with start high and busy low
//   - results leave on out_* for one cycle each, marked by out_strobe; the
//     receiver cannot stall, so every strobed beat must be captured
//   - out_last marks the final result beat caused by a command
// command handling
//   - tick walks all slots through the slot ram, one slot per cycle, busy high
//     throughout; each fire beat is held in the result stage until the next
//     fire or the walk's closing flush; a tick with no firing gives none
//   - add scans the occupancy bits one slot per cycle, up to the first free one
//   - cancel, reap, pause, resume: one ram read then write back
//   - immediate rejections leave busy low, reply via the event and result
//     registers; other replies come in the cycle after busy drops
//   - at most 16 fire beats per tick; all slots are still counted down
// reset
//   - synchronous, active low; all slots read as empty afterwards, the slot
//     ram itself is not cleared (entries are written by add before use)
// ----------------------------------------------------------------------------
`default_nettype none

module multi_slot_countdown_timer_core
  import mscd_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // command channel
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    in_command,
  input  wire logic [SLOT_W-1:0]   in_slot,
  input  wire logic [PORT_PER-1:0] in_period,
  input  wire logic                in_repeat_req,
  // result channel
  output logic                     out_strobe,
  output logic                     out_kind,
  output logic [SLOT_W-1:0]        out_slot_out,
  output logic [STATUS_W-1:0]      out_status,
  output logic                     out_freed,
  output logic                     out_last
);

  // ram address width and entry width: mode, repeat flag, ticks left, period
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DW = MODE_W + 1 + 2 * PERIOD_BITS;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  evt_t          evt;

  // sequencer: owns occupancy bits and does the read-modify-write of entries
  mscd_engine #(
    .SLOTS       (SLOTS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_slot       (in_slot),
    .in_period     (in_period),
    .in_repeat_req (in_repeat_req),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .evt           (evt)
  );

  // per-slot mode, repeat flag, countdown and reload period
  mscd_slot_ram #(
    .DEPTH  (SLOTS),
    .DATA_W (DW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result register; one fire beat is held so the final one carries last
  mscd_result_stage u_result (
    .clk          (clk),
    .rst_n        (rst_n),
    .evt          (evt),
    .out_strobe   (out_strobe),
    .out_kind     (out_kind),
    .out_slot_out (out_slot_out),
    .out_status   (out_status),
    .out_freed    (out_freed),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

>>> tb/multi_slot_countdown_timer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer_core_tb
// self-checking bench: a slot table model predicts every reply and fire beat,
// commands come from a directed list, two table-wide storms and a weighted
// random mix, with random gaps between commands
// ----------------------------------------------------------------------------

module multi_slot_countdown_timer_core_tb
  import mscd_pkg::*;
();

  localparam int NSLOT = SLOTS_DEF;
  localparam int ITEM_TOTAL = 360;

  // command codes the block does not define, answered as invalid
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  // result kinds
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_FIRE  = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
    logic                freed;
    logic                last;
  } beat_t;

  // slot table model plus the queue of beats still owed by the block
  class slot_table_scoreboard;
    mode_t               slot_mode[NSLOT];
    logic [PORT_PER-1:0] reload_val[NSLOT];
    logic [PORT_PER-1:0] count_left[NSLOT];
    logic                rearm[NSLOT];
    beat_t               awaited_beats[$];
    int                  errors;

    function new();
      foreach (slot_mode[i]) slot_mode[i] = MODE_EMPTY;
      errors = 0;
    endfunction

    function void owe_reply(logic [SLOT_W-1:0] s, status_t st, logic fr);
      awaited_beats.push_back(beat_t'{KIND_REPLY, s, st, fr, 1'b1});
    endfunction

    // called once per accepted command beat
    function void note_command(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] s,
                               logic [PORT_PER-1:0] per, logic rep);
      beat_t   fires[$];
      int      idx;
      status_t st;
      logic    fr;
      idx = int'(s);
      case (cmd)
        CMD_TICK: begin
          // walk in slot order, every running slot counts down
          for (int i = 0; i < NSLOT; i++) begin
            if (slot_mode[i] == MODE_RUN) begin
              count_left[i] = count_left[i] - 1'b1;
              if (count_left[i] == '0) begin
                if (fires.size() < MAX_RESULTS)
                  fires.push_back(beat_t'{KIND_FIRE, SLOT_W'(i), ST_OK, 1'b0, 1'b0});
                if (rearm[i]) count_left[i] = reload_val[i];
                else slot_mode[i] = MODE_OVER;
              end
            end
          end
          if (fires.size() > 0) fires[fires.size()-1].last = 1'b1;
          foreach (fires[k]) awaited_beats.push_back(fires[k]);
        end
        CMD_ADD: begin
          idx = -1;
          if (per == '0) begin
            owe_reply('0, ST_INVALID, 1'b0);
          end else begin
            for (int i = 0; i < NSLOT; i++)
              if (idx < 0 && slot_mode[i] == MODE_EMPTY) idx = i;
            if (idx < 0) begin
              owe_reply('0, ST_NOSPACE, 1'b0);
            end else begin
              slot_mode[idx]  = MODE_RUN;
              reload_val[idx] = per;
              count_left[idx] = per;
              rearm[idx]      = rep;
              owe_reply(SLOT_W'(idx), ST_OK, 1'b0);
            end
          end
        end
        CMD_CANCEL, CMD_REAP, CMD_PAUSE, CMD_RESUME: begin
          if (idx >= NSLOT || slot_mode[idx] == MODE_EMPTY) begin
            owe_reply(s, ST_INVALID, 1'b0);
          end else begin
            st = ST_OK;
            fr = 1'b0;
            case (cmd)
              CMD_CANCEL: begin
                if (slot_mode[idx] == MODE_OVER) begin
                  st = ST_BUSY;
                end else begin
                  slot_mode[idx] = MODE_CANCEL;
                  rearm[idx]     = 1'b0;
                end
              end
              CMD_REAP: begin
                if (rearm[idx]) begin
                  st = ST_BUSY;
                end else if (slot_mode[idx] == MODE_RUN) begin
                  st = ST_PENDING;
                end else if (slot_mode[idx] == MODE_CANCEL || slot_mode[idx] == MODE_OVER) begin
                  slot_mode[idx] = MODE_EMPTY;
                  fr = 1'b1;
                end
              end
              CMD_PAUSE: begin
                if (slot_mode[idx] != MODE_RUN) st = ST_WRONG;
                else slot_mode[idx] = MODE_PAUSE;
              end
              default: begin
                if (slot_mode[idx] != MODE_PAUSE) st = ST_WRONG;
                else slot_mode[idx] = MODE_RUN;
              end
            endcase
            owe_reply(s, st, fr);
          end
        end
        default: owe_reply('0, ST_INVALID, 1'b0);
      endcase
    endfunction

    // called once per strobed result beat
    function void check_beat(beat_t got);
      beat_t want;
      if (awaited_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat kind=%0d slot=%0d status=%0d freed=%0d last=%0d",
                 $time, got.kind, got.slot, got.status, got.freed, got.last);
        return;
      end
      want = awaited_beats.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: beat mismatch expected kind=%0d slot=%0d status=%0d freed=%0d last=%0d",
                 $time, want.kind, want.slot, want.status, want.freed, want.last);
        $display("%0t:                  actual kind=%0d slot=%0d status=%0d freed=%0d last=%0d",
                 $time, got.kind, got.slot, got.status, got.freed, got.last);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    in_command;
  logic [SLOT_W-1:0]   in_slot;
  logic [PORT_PER-1:0] in_period;
  logic                in_repeat_req;
  logic                out_strobe;
  logic                out_kind;
  logic [SLOT_W-1:0]   out_slot_out;
  logic [STATUS_W-1:0] out_status;
  logic                out_freed;
  logic                out_last;

  slot_table_scoreboard slot_sb = new();
  int                   items_sent = 0;

  multi_slot_countdown_timer_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_slot       (in_slot),
    .in_period     (in_period),
    .in_repeat_req (in_repeat_req),
    .out_strobe    (out_strobe),
    .out_kind      (out_kind),
    .out_slot_out  (out_slot_out),
    .out_status    (out_status),
    .out_freed     (out_freed),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // everything is sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        slot_sb.note_command(in_command, in_slot, in_period, in_repeat_req);
      if (out_strobe)
        slot_sb.check_beat(beat_t'{out_kind, out_slot_out, out_status, out_freed, out_last});
    end
  end

  // hold a command beat until the block takes it
  task automatic issue(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] s,
                       logic [PORT_PER-1:0] per, logic rep);
    @(negedge clk);
    start         <= 1'b1;
    in_command    <= cmd;
    in_slot       <= s;
    in_period     <= per;
    in_repeat_req <= rep;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic idle(int n);
    if (n <= 0) return;
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // mostly back to back or short gaps, now and then a long one
  task automatic send(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] s,
                      logic [PORT_PER-1:0] per, logic rep);
    int r;
    issue(cmd, s, per, rep);
    r = $urandom_range(99);
    if (r < 55) idle(0);
    else if (r < 90) idle($urandom_range(3, 1));
    else idle($urandom_range(40, 8));
  endtask

  // empty the whole table, refill it with period 1 slots past full, then tick
  task automatic storm();
    for (int s = 0; s < NSLOT; s++) begin
      send(CMD_CANCEL, SLOT_W'(s), PORT_PER'($urandom), 1'($urandom_range(1)));
      send(CMD_REAP, SLOT_W'(s), PORT_PER'($urandom), 1'($urandom_range(1)));
    end
    for (int k = 0; k <= NSLOT; k++)
      send(CMD_ADD, SLOT_W'($urandom), 16'd1, 1'($urandom_range(1)));
    send(CMD_TICK, SLOT_W'($urandom), PORT_PER'($urandom), 1'($urandom_range(1)));
    send(CMD_TICK, SLOT_W'($urandom), PORT_PER'($urandom), 1'($urandom_range(1)));
  endtask

  // weighted mix, aimed mostly at real slots and short periods
  task automatic random_command();
    int                  r;
    logic [CMD_W-1:0]    cmd;
    logic [SLOT_W-1:0]   s;
    logic [PORT_PER-1:0] per;
    r = $urandom_range(99);
    if (r < 33) cmd = CMD_TICK;
    else if (r < 58) cmd = CMD_ADD;
    else if (r < 69) cmd = CMD_CANCEL;
    else if (r < 81) cmd = CMD_REAP;
    else if (r < 89) cmd = CMD_PAUSE;
    else if (r < 97) cmd = CMD_RESUME;
    else if (r < 98) cmd = CMD_SPARE_A;
    else cmd = CMD_SPARE_B;
    s = ($urandom_range(99) < 88) ? SLOT_W'($urandom_range(NSLOT - 1)) : SLOT_W'($urandom);
    r = $urandom_range(99);
    if (r < 8) per = '0;
    else if (r < 78) per = PORT_PER'($urandom_range(4, 1));
    else if (r < 90) per = PORT_PER'($urandom_range(40, 5));
    else per = PORT_PER'($urandom);
    send(cmd, s, per, 1'($urandom_range(1)));
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_command    = CMD_TICK;
    in_slot       = '0;
    in_period     = '0;
    in_repeat_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    send(CMD_TICK, 0, 0, 0);          // empty table, tick gives no beat
    send(CMD_ADD, 0, 16'h0000, 1);    // zero period rejected
    send(CMD_ADD, 0, 16'd1, 0);       // slot 0, one-shot
    send(CMD_ADD, 63, 16'hFFFF, 1);   // slot 1, longest period, repeat
    send(CMD_ADD, 0, 16'd2, 1);       // slot 2, repeat
    send(CMD_CANCEL, 63, 16'hFFFF, 1); // slot out of range
    send(CMD_REAP, 15, 0, 0);         // empty slot
    send(CMD_PAUSE, 1, 0, 0);
    send(CMD_PAUSE, 1, 0, 0);         // already paused
    send(CMD_RESUME, 0, 0, 0);        // running, not paused
    send(CMD_RESUME, 1, 0, 0);
    send(CMD_REAP, 2, 0, 0);          // repeat slot is busy
    send(CMD_REAP, 0, 0, 0);          // one-shot still running
    send(CMD_TICK, 0, 0, 0);          // slot 0 fires and is over
    send(CMD_TICK, 0, 0, 0);          // slot 2 fires and reloads
    send(CMD_CANCEL, 0, 0, 0);        // over slot answers busy
    send(CMD_REAP, 0, 0, 0);          // over slot freed
    send(CMD_ADD, 0, 16'd5, 0);
    send(CMD_PAUSE, 0, 0, 0);
    send(CMD_REAP, 0, 0, 0);          // paused one-shot, nothing freed
    send(CMD_CANCEL, 0, 0, 0);        // cancel from paused
    send(CMD_CANCEL, 0, 0, 0);        // cancel again
    send(CMD_REAP, 0, 0, 0);
    send(CMD_CANCEL, 2, 0, 0);        // clears the repeat flag
    send(CMD_REAP, 2, 0, 0);
    send(CMD_SPARE_A, 5, 16'd3, 0);
    send(CMD_SPARE_B, 63, 16'hFFFF, 1);

    // random part with two storms along the way
    storm();
    while (items_sent < ITEM_TOTAL) begin
      if (items_sent >= 220 && items_sent < 221) storm();
      random_command();
    end
    idle(1);

    // drain, then watch for stray beats a little longer than one tick walk
    while (slot_sb.awaited_beats.size() != 0) @(posedge clk);
    repeat (NSLOT + 10) @(posedge clk);
    if (slot_sb.errors == 0) begin
      $display("** multi_slot_countdown_timer_core: PASSED **");
    end else begin
      $display("** multi_slot_countdown_timer_core: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("** multi_slot_countdown_timer_core: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/mscd_pkg.sv
rtl/core/mscd_slot_ram.sv
rtl/core/mscd_result_stage.sv
rtl/core/mscd_engine.sv
rtl/core/multi_slot_countdown_timer_core.sv
tb/multi_slot_countdown_timer_core_tb.sv
